[sv/crq7_pkg.sv]
// Shared constants, types and functions of the 8-bit CORDIC rotator.
package crq7_pkg;

  localparam int unsigned ITERATIONS_DEF = 8;
  localparam int unsigned ITERATIONS_MAX = 8;

  localparam int unsigned ANGLE_W = 10;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned XY_W    = 16;
  localparam int unsigned ACC_W   = 10;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned FRAC_W  = 7;

  localparam int unsigned QUARTER_TURN = 201;
  localparam logic [ANGLE_W-1:0] ANGLE_MASK = 10'b1111111100;

  localparam int SAT_MAX = 127;
  localparam int SAT_MIN = -128;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] a;
    logic [1:0]              quad;
  } crq7_rot_t;

  function automatic logic signed [ACC_W-1:0] crq7_atan(input logic [2:0] idx);
    logic signed [ACC_W-1:0] v;
    case (idx)
      3'd0: v = 10'sh065;
      3'd1: v = 10'sh03B;
      3'd2: v = 10'sh01F;
      3'd3: v = 10'sh010;
      3'd4: v = 10'sh008;
      3'd5: v = 10'sh004;
      3'd6: v = 10'sh002;
      3'd7: v = 10'sh001;
      default: v = 10'sh000;
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] crq7_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-FRAC_W-1:0] r;
    logic signed [DATA_W-1:0]       v;
    r = (SUM_W-FRAC_W)'(s >>> FRAC_W);
    if (r > SAT_MAX) begin
      v = DATA_W'(SAT_MAX);
    end else if (r < SAT_MIN) begin
      v = DATA_W'(SAT_MIN);
    end else begin
      v = r[DATA_W-1:0];
    end
    return v;
  endfunction

endpackage

[sv/crq7_if.sv]
// Valid/ready channel interfaces for the rotator input and result streams.
interface crq7_in_if;
  import crq7_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ANGLE_W-1:0]         angle;
  logic signed [DATA_W-1:0]   x_in;
  logic signed [DATA_W-1:0]   y_in;

  modport source (output valid, output angle, output x_in, output y_in, input ready);
  modport sink   (input valid, input angle, input x_in, input y_in, output ready);
endinterface

interface crq7_out_if;
  import crq7_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   x_out;
  logic signed [DATA_W-1:0]   y_out;

  modport source (output valid, output x_out, output y_out, input ready);
  modport sink   (input valid, input x_out, input y_out, output ready);
endinterface

[sv/crq7_stage.sv]
// One registered CORDIC micro-rotation stage.
module crq7_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  crq7_pkg::crq7_rot_t data_i,
  output logic                valid_o,
  output crq7_pkg::crq7_rot_t data_o
);
  import crq7_pkg::*;

  logic signed [XY_W-1:0]  sx;
  logic signed [XY_W-1:0]  sy;
  logic signed [ACC_W-1:0] atan;
  crq7_rot_t               data_d;
  crq7_rot_t               data_q;
  logic                    valid_q;

  assign sx   = data_i.x >>> SHIFT;
  assign sy   = data_i.y >>> SHIFT;
  assign atan = crq7_atan(3'(SHIFT));

  always_comb begin
    data_d.quad = data_i.quad;
    if (!data_i.a[ACC_W-1]) begin
      data_d.x = data_i.x - sy;
      data_d.y = data_i.y + sx;
      data_d.a = data_i.a - atan;
    end else begin
      data_d.x = data_i.x + sy;
      data_d.y = data_i.y - sx;
      data_d.a = data_i.a + atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/cordic_rotator_q7_top.sv]
// Top level of the pipelined 8-bit CORDIC vector rotator.
//
//   channel  dir  payload                   transfer
//   in_i     in   angle, x_in, y_in         valid && ready
//   out_o    out  x_out, y_out              valid && ready
//
// Registers in order: angle reduction, one stage per micro-rotation,
// gain scaling, then saturation and quadrant turn into the output.
// One item enters every cycle while the output is not stalled; each stage holds one item.
// Reset clears every stage valid bit; data registers are not reset.
// A stalled output freezes the whole pipeline, so input ready drops.
module cordic_rotator_q7_top #(
  parameter int unsigned ITERATIONS = crq7_pkg::ITERATIONS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crq7_in_if.sink    in_i,
  crq7_out_if.source out_o
);
  import crq7_pkg::*;

  logic                     en;
  logic [ANGLE_W-1:0]       ang_m;
  logic [ANGLE_W-1:0]       rem;
  logic [1:0]               quad;
  crq7_rot_t                red_d;

  logic [ITERATIONS:0]      stg_valid;
  crq7_rot_t                stg_data [ITERATIONS+1];

  logic                     red_valid_q;
  crq7_rot_t                red_q;

  logic signed [SUM_W-1:0]  scl_x_d;
  logic signed [SUM_W-1:0]  scl_y_d;
  logic signed [SUM_W-1:0]  scl_x_q;
  logic signed [SUM_W-1:0]  scl_y_q;
  logic [1:0]               scl_quad_q;
  logic                     scl_valid_q;

  logic signed [DATA_W-1:0] sat_x;
  logic signed [DATA_W-1:0] sat_y;
  logic signed [DATA_W-1:0] rot_x_d;
  logic signed [DATA_W-1:0] rot_y_d;
  logic signed [DATA_W-1:0] out_x_q;
  logic signed [DATA_W-1:0] out_y_q;
  logic                     out_valid_q;

  assign en         = out_o.ready || !out_valid_q;
  assign in_i.ready = en;

  assign ang_m = in_i.angle & ANGLE_MASK;

  always_comb begin
    if (ang_m >= ANGLE_W'(5 * QUARTER_TURN)) begin
      quad = QUAD_1;
      rem  = ang_m - ANGLE_W'(5 * QUARTER_TURN);
    end else if (ang_m >= ANGLE_W'(4 * QUARTER_TURN)) begin
      quad = QUAD_0;
      rem  = ang_m - ANGLE_W'(4 * QUARTER_TURN);
    end else if (ang_m >= ANGLE_W'(3 * QUARTER_TURN)) begin
      quad = QUAD_3;
      rem  = ang_m - ANGLE_W'(3 * QUARTER_TURN);
    end else if (ang_m >= ANGLE_W'(2 * QUARTER_TURN)) begin
      quad = QUAD_2;
      rem  = ang_m - ANGLE_W'(2 * QUARTER_TURN);
    end else if (ang_m >= ANGLE_W'(QUARTER_TURN)) begin
      quad = QUAD_1;
      rem  = ang_m - ANGLE_W'(QUARTER_TURN);
    end else begin
      quad = QUAD_0;
      rem  = ang_m;
    end
    red_d.x    = {in_i.x_in[DATA_W-1], in_i.x_in, FRAC_W'(0)};
    red_d.y    = {in_i.y_in[DATA_W-1], in_i.y_in, FRAC_W'(0)};
    red_d.a    = $signed(ACC_W'(rem));
    red_d.quad = quad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_valid_q <= 1'b0;
    end else if (en) begin
      red_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q <= red_d;
    end
  end

  assign stg_valid[0] = red_valid_q;
  assign stg_data[0]  = red_q;

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
    crq7_stage #(
      .SHIFT(k)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(stg_valid[k]),
      .data_i (stg_data[k]),
      .valid_o(stg_valid[k+1]),
      .data_o (stg_data[k+1])
    );
  end

  assign scl_x_d = SUM_W'(stg_data[ITERATIONS].x >>> 6) + SUM_W'(stg_data[ITERATIONS].x >>> 5)
                 + SUM_W'(stg_data[ITERATIONS].x >>> 4) + SUM_W'(stg_data[ITERATIONS].x >>> 1);
  assign scl_y_d = SUM_W'(stg_data[ITERATIONS].y >>> 6) + SUM_W'(stg_data[ITERATIONS].y >>> 5)
                 + SUM_W'(stg_data[ITERATIONS].y >>> 4) + SUM_W'(stg_data[ITERATIONS].y >>> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_valid_q <= 1'b0;
    end else if (en) begin
      scl_valid_q <= stg_valid[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      scl_x_q    <= scl_x_d;
      scl_y_q    <= scl_y_d;
      scl_quad_q <= stg_data[ITERATIONS].quad;
    end
  end

  assign sat_x = crq7_sat(scl_x_q);
  assign sat_y = crq7_sat(scl_y_q);

  always_comb begin
    case (scl_quad_q)
      QUAD_1: begin
        rot_x_d = DATA_W'(-sat_y);
        rot_y_d = sat_x;
      end
      QUAD_2: begin
        rot_x_d = DATA_W'(-sat_x);
        rot_y_d = DATA_W'(-sat_y);
      end
      QUAD_3: begin
        rot_x_d = sat_y;
        rot_y_d = DATA_W'(-sat_x);
      end
      default: begin
        rot_x_d = sat_x;
        rot_y_d = sat_y;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= scl_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q <= rot_x_d;
      out_y_q <= rot_y_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.x_out = out_x_q;
  assign out_o.y_out = out_y_q;

endmodule

[sv/crq7_checker.sv]
// Port-level assertions for the CORDIC rotator and their bind.
module crq7_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [7:0]         x_out_i,
  input logic signed [7:0]         y_out_i
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked while result slot is empty");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input transfer while result is stalled");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(x_out_i) && $stable(y_out_i))
    else $error("stalled result changed");

  a_ready_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && out_ready_i |-> in_ready_i)
    else $error("offered transfer blocked while result side is ready");

endmodule

bind cordic_rotator_q7_top crq7_checker u_crq7_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .x_out_i    (out_o.x_out),
  .y_out_i    (out_o.y_out)
);
